@@ rtl/core/itc_pkg.sv @@
// ----------------------------------------------------------------------------
// itc_pkg
// Shared types and constants for the integer to text converter.
// ----------------------------------------------------------------------------
package itc_pkg;

  // Conversion kinds
  localparam logic [2:0] KIND_SDEC   = 3'd0;
  localparam logic [2:0] KIND_UDEC   = 3'd1;
  localparam logic [2:0] KIND_HEXL   = 3'd2;
  localparam logic [2:0] KIND_HEXU   = 3'd3;
  localparam logic [2:0] KIND_BIN    = 3'd4;
  localparam logic [2:0] KIND_BINSP  = 3'd5;
  localparam logic [2:0] KIND_SIZE1K = 3'd6;
  localparam logic [2:0] KIND_SIZE1M = 3'd7;

  localparam int unsigned NUM_DIGITS = 10;   // max decimal digits of a 32-bit value
  localparam int unsigned DIG_IDX_W  = 4;
  localparam int unsigned CNT_W      = 6;

  localparam logic [31:0] LIMIT_1K  = 32'd1024;
  localparam logic [31:0] LIMIT_1M  = 32'd1048576;
  localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;  // ceil(2^35 / 10)

  // ASCII
  localparam logic [6:0] CHR_ZERO  = 7'h30;
  localparam logic [6:0] CHR_ONE   = 7'h31;
  localparam logic [6:0] CHR_MINUS = 7'h2D;
  localparam logic [6:0] CHR_SPACE = 7'h20;
  localparam logic [6:0] CHR_X     = 7'h78;
  localparam logic [6:0] CHR_B     = 7'h42;
  localparam logic [6:0] CHR_K     = 7'h4B;
  localparam logic [6:0] CHR_M     = 7'h4D;
  localparam logic [6:0] CHR_G     = 7'h47;
  localparam logic [6:0] CHR_LC_A  = 7'h61;
  localparam logic [6:0] CHR_UC_A  = 7'h41;

  typedef enum logic [3:0] {
    SEL_MINUS,
    SEL_ZERO,
    SEL_X,
    SEL_DIG,
    SEL_HEX,
    SEL_BIT,
    SEL_SPACE,
    SEL_UNIT,
    SEL_B
  } char_sel_e;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  kind;
    logic        hex_prefix;
  } in_t;

  typedef struct packed {
    logic [6:0] text_char;
    logic       last;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic      load;
    logic      norm_step;
    logic      div_step;
    logic      shl4;
    logic      shl1;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      emit;
    char_sel_e sel;
    logic      last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0]       kind;
    logic             pfx;
    logic             neg;
    logic             ge_limit;
    logic             q_zero;
    logic [CNT_W-1:0] cnt;
    logic [1:0]       steps;
    logic             out_free;
  } sts_t;

endpackage

@@ rtl/core/itc_datapath.sv @@
// ----------------------------------------------------------------------------
// itc_datapath
// Value register, digit store, counter, character select and output register.
// ----------------------------------------------------------------------------
module itc_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  itc_pkg::in_t  in_data_i,
  input  itc_pkg::cmd_t cmd_i,
  output itc_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output itc_pkg::out_t out_data_o
);
  import itc_pkg::*;

  logic [31:0]          val_q, val_d;
  logic [2:0]           kind_q;
  logic                 pfx_q;
  logic                 neg_q;
  logic [1:0]           steps_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [3:0]           dig_q [NUM_DIGITS];
  out_t                 out_q;
  logic                 out_vld_q;

  logic [63:0]          prod;
  logic [31:0]          quot;
  logic [31:0]          rem_full;
  logic [3:0]           rem;
  logic [CNT_W-1:0]     cnt_m1;
  logic [3:0]           dig_rd;
  logic [3:0]           nib;
  logic [6:0]           ch;
  logic                 neg_in;

  // divide by ten: multiply by reciprocal, remainder by shift-add
  assign prod     = 64'(val_q) * 64'(RECIP_TEN);
  assign quot     = 32'(prod >> 35);
  assign rem_full = val_q - ((quot << 3) + (quot << 1));
  assign rem      = rem_full[3:0];

  assign cnt_m1 = cnt_q - CNT_W'(1);
  assign dig_rd = dig_q[cnt_m1[DIG_IDX_W-1:0]];
  assign nib    = val_q[31:28];
  assign neg_in = (in_data_i.kind == KIND_SDEC) && in_data_i.value[31];

  always_comb begin
    val_d = val_q;
    if (cmd_i.load) begin
      val_d = neg_in ? (32'd0 - in_data_i.value) : in_data_i.value;
    end else if (cmd_i.norm_step) begin
      val_d = val_q >> 10;
    end else if (cmd_i.div_step) begin
      val_d = quot;
    end else if (cmd_i.shl4) begin
      val_d = val_q << 4;
    end else if (cmd_i.shl1) begin
      val_d = val_q << 1;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      cnt_d = '0;
    end else if (cmd_i.div_step || cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_m1;
    end
  end

  always_comb begin
    case (cmd_i.sel)
      SEL_MINUS: ch = CHR_MINUS;
      SEL_ZERO:  ch = CHR_ZERO;
      SEL_X:     ch = CHR_X;
      SEL_DIG:   ch = CHR_ZERO | {3'd0, dig_rd};
      SEL_HEX: begin
        if (nib < 4'd10) begin
          ch = CHR_ZERO | {3'd0, nib};
        end else begin
          ch = ((kind_q == KIND_HEXU) ? CHR_UC_A : CHR_LC_A) + {3'd0, nib - 4'd10};
        end
      end
      SEL_BIT:   ch = val_q[31] ? CHR_ONE : CHR_ZERO;
      SEL_SPACE: ch = CHR_SPACE;
      SEL_UNIT: begin
        case (steps_q)
          2'd1:    ch = CHR_K;
          2'd2:    ch = CHR_M;
          default: ch = CHR_G;
        endcase
      end
      SEL_B:     ch = CHR_B;
      default:   ch = CHR_SPACE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
      steps_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.load) begin
        steps_q <= '0;
      end else if (cmd_i.norm_step) begin
        steps_q <= steps_q + 2'd1;
      end
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    if (cmd_i.load) begin
      kind_q <= in_data_i.kind;
      pfx_q  <= in_data_i.hex_prefix;
      neg_q  <= neg_in;
    end
    if (cmd_i.div_step) begin
      dig_q[cnt_q[DIG_IDX_W-1:0]] <= rem;
    end
    if (cmd_i.emit) begin
      out_q.text_char <= ch;
      out_q.last      <= cmd_i.last;
    end
  end

  always_comb begin
    sts_o.kind     = kind_q;
    sts_o.pfx      = pfx_q;
    sts_o.neg      = neg_q;
    sts_o.ge_limit = (kind_q == KIND_SIZE1K) ? (val_q >= LIMIT_1K) : (val_q >= LIMIT_1M);
    sts_o.q_zero   = (quot == 32'd0);
    sts_o.cnt      = cnt_q;
    sts_o.steps    = steps_q;
    sts_o.out_free = !out_vld_q || !out_stall_i;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/core/itc_ctrl.sv @@
// ----------------------------------------------------------------------------
// itc_ctrl
// Sequencer: load, size scaling, digit extraction and character emission.
// ----------------------------------------------------------------------------
module itc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  itc_pkg::sts_t sts_i,
  output itc_pkg::cmd_t cmd_o
);
  import itc_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_NORM  = 4'd2;
  localparam logic [3:0] ST_DIV   = 4'd3;
  localparam logic [3:0] ST_SIGN  = 4'd4;
  localparam logic [3:0] ST_DEC   = 4'd5;
  localparam logic [3:0] ST_SPC   = 4'd6;
  localparam logic [3:0] ST_UNIT  = 4'd7;
  localparam logic [3:0] ST_BCH   = 4'd8;
  localparam logic [3:0] ST_PFX0  = 4'd9;
  localparam logic [3:0] ST_PFXX  = 4'd10;
  localparam logic [3:0] ST_HEX   = 4'd11;
  localparam logic [3:0] ST_BIN   = 4'd12;
  localparam logic [3:0] ST_BSP   = 4'd13;

  logic [3:0] state_q, state_d;
  logic       is_size;
  logic       go;

  assign is_size = (sts_i.kind == KIND_SIZE1K) || (sts_i.kind == KIND_SIZE1M);
  assign go      = sts_i.out_free;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.sel = SEL_SPACE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        unique case (sts_i.kind) inside
          KIND_SDEC, KIND_UDEC:     state_d = ST_DIV;
          KIND_SIZE1K, KIND_SIZE1M: state_d = ST_NORM;
          KIND_HEXL, KIND_HEXU:     state_d = sts_i.pfx ? ST_PFX0 : ST_HEX;
          default:                  state_d = ST_BIN;
        endcase
      end
      ST_NORM: begin
        if (sts_i.ge_limit) begin
          cmd_o.norm_step = 1'b1;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.q_zero) begin
          state_d = sts_i.neg ? ST_SIGN : ST_DEC;
        end
      end
      ST_SIGN: begin
        cmd_o.emit = go;
        cmd_o.sel  = SEL_MINUS;
        if (go) state_d = ST_DEC;
      end
      ST_DEC: begin
        cmd_o.emit    = go;
        cmd_o.sel     = SEL_DIG;
        cmd_o.cnt_dec = go;
        cmd_o.last    = (sts_i.cnt == CNT_W'(1)) && !is_size;
        if (go && sts_i.cnt == CNT_W'(1)) begin
          state_d = is_size ? ST_SPC : ST_IDLE;
        end
      end
      ST_SPC: begin
        cmd_o.emit = go;
        cmd_o.sel  = SEL_SPACE;
        if (go) state_d = (sts_i.steps != 2'd0) ? ST_UNIT : ST_BCH;
      end
      ST_UNIT: begin
        cmd_o.emit = go;
        cmd_o.sel  = SEL_UNIT;
        if (go) state_d = ST_BCH;
      end
      ST_BCH: begin
        cmd_o.emit = go;
        cmd_o.sel  = SEL_B;
        cmd_o.last = 1'b1;
        if (go) state_d = ST_IDLE;
      end
      ST_PFX0: begin
        cmd_o.emit = go;
        cmd_o.sel  = SEL_ZERO;
        if (go) state_d = ST_PFXX;
      end
      ST_PFXX: begin
        cmd_o.emit = go;
        cmd_o.sel  = SEL_X;
        if (go) state_d = ST_HEX;
      end
      ST_HEX: begin
        cmd_o.emit    = go;
        cmd_o.sel     = SEL_HEX;
        cmd_o.shl4    = go;
        cmd_o.cnt_inc = go;
        cmd_o.last    = (sts_i.cnt == CNT_W'(7));
        if (go && sts_i.cnt == CNT_W'(7)) state_d = ST_IDLE;
      end
      ST_BIN: begin
        cmd_o.emit    = go;
        cmd_o.sel     = SEL_BIT;
        cmd_o.shl1    = go;
        cmd_o.cnt_inc = go;
        cmd_o.last    = (sts_i.kind == KIND_BIN) && (sts_i.cnt == CNT_W'(31));
        if (go) begin
          if (sts_i.kind == KIND_BINSP && sts_i.cnt[2:0] == 3'd7) begin
            state_d = ST_BSP;
          end else if (sts_i.cnt == CNT_W'(31)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_BSP: begin
        cmd_o.emit = go;
        cmd_o.sel  = SEL_SPACE;
        cmd_o.last = (sts_i.cnt == CNT_W'(32));
        if (go) state_d = (sts_i.cnt == CNT_W'(32)) ? ST_IDLE : ST_BIN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/integer_to_text_converter_unit.sv @@
// ----------------------------------------------------------------------------
// integer_to_text_converter_unit
// Converts a 32-bit value to ASCII text, one character per transaction.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o  | value, kind, hex_prefix
// out     | output    | out_valid_o / out_stall_i| text_char, last
//
// One value at a time. After acceptance: a dispatch state, then for size
// kinds one /1024 step per threshold crossing (up to 3) plus one compare,
// for decimal and size kinds one digit per divide-by-ten step (up to 10),
// then the characters (1 to 36), each emitted when the output is free.
// Reset clears the sequencer and the output valid; no clearing pass.
// A stalled output holds its character and freezes the emitting states; the
// next value is taken in the cycle after the last character is registered.
// ----------------------------------------------------------------------------
module integer_to_text_converter_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  itc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output itc_pkg::out_t out_data_o
);
  import itc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  itc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // value, digit store and output register
  itc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for integer_to_text_converter_unit. Values go in over
// the valid/stall input channel. For each accepted transaction a local model
// works out the expected characters and their last marks and queues them.
// A monitor compares every accepted output transaction with the oldest
// queued character, field by field. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import itc_pkg::*;

  localparam logic [31:0] SIZE_DIVISOR = 32'd1024;
  localparam int unsigned DRAIN_CYCLES = 60;       // idle margin after the last expected character
  localparam int unsigned RUN_LIMIT_NS = 5_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  // Characters still owed by the block, oldest first
  out_t       expected_chars[$];
  logic [6:0] text_buf[$];
  int         error_count = 0;

  // Sender burst shaping: max_gap of 0 keeps valid high back to back
  int burst_left = 0;
  int max_gap = 0;

  // Receiver stall shaping
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  out_t want_char;

  integer_to_text_converter_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Text model
  // --------------------------------------------------------------------------
  function automatic void append_decimal(input logic [31:0] mag);
    logic [6:0] digits[$];
    digits = {};
    do begin
      digits.push_front(CHR_ZERO + 7'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    foreach (digits[k]) text_buf.push_back(digits[k]);
  endfunction

  // Builds the text for one value and queues it with the last mark on the tail
  function automatic void render_text(input in_t item);
    logic [31:0] v;
    logic [31:0] limit;
    logic [3:0]  nib;
    logic [6:0]  base;
    int          steps;
    int          i;
    out_t        ch;
    text_buf = {};
    v = item.value;
    case (item.kind)
      KIND_SDEC: begin
        if (v[31]) begin
          text_buf.push_back(CHR_MINUS);
          v = 32'd0 - v;     // unsigned magnitude, safe for the most negative value
        end
        append_decimal(v);
      end
      KIND_UDEC: begin
        append_decimal(v);
      end
      KIND_HEXL, KIND_HEXU: begin
        base = (item.kind == KIND_HEXU) ? CHR_UC_A : CHR_LC_A;
        if (item.hex_prefix) begin
          text_buf.push_back(CHR_ZERO);
          text_buf.push_back(CHR_X);
        end
        for (i = 7; i >= 0; i--) begin
          nib = v[i*4 +: 4];
          text_buf.push_back((nib < 4'd10) ? CHR_ZERO + 7'(nib) : base + 7'(nib - 4'd10));
        end
      end
      KIND_BIN, KIND_BINSP: begin
        for (i = 31; i >= 0; i--) begin
          text_buf.push_back(v[i] ? CHR_ONE : CHR_ZERO);
          if (item.kind == KIND_BINSP && (i % 8) == 0) text_buf.push_back(CHR_SPACE);
        end
      end
      default: begin
        limit = (item.kind == KIND_SIZE1K) ? LIMIT_1K : LIMIT_1M;
        steps = 0;
        while (v >= limit) begin
          v = v / SIZE_DIVISOR;
          steps++;
        end
        append_decimal(v);
        text_buf.push_back(CHR_SPACE);
        case (steps)
          0: ;
          1: text_buf.push_back(CHR_K);
          2: text_buf.push_back(CHR_M);
          default: text_buf.push_back(CHR_G);
        endcase
        text_buf.push_back(CHR_B);
      end
    endcase
    foreach (text_buf[k]) begin
      ch.text_char = text_buf[k];
      ch.last = (k == text_buf.size() - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender: called at a falling edge, returns at a falling edge after the
  // transaction was taken. Gaps only fall between bursts.
  // --------------------------------------------------------------------------
  task automatic send_value(input in_t item);
    if (burst_left == 0) begin
      if (max_gap != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, max_gap)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_data_i  <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    render_text(item);
    burst_left--;
    @(negedge clk_i);
  endtask

  function automatic in_t make_item(input logic [31:0] value, input logic [2:0] kind,
                                    input logic pfx);
    in_t item;
    item.value = value;
    item.kind = kind;
    item.hex_prefix = pfx;
    return item;
  endfunction

  // Values biased toward decimal carries and size thresholds
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 2100);
      2: v = (32'd1 << $urandom_range(0, 31)) + 32'($urandom_range(0, 2)) - 32'd1;
      3: v = (32'($urandom_range(1, 1023)) << (10 * $urandom_range(0, 2)))
             + 32'($urandom_range(0, 3)) - 32'd1;
      4: v = {1'b1, 31'($urandom())};
      default: begin
        v = 32'd1;
        repeat ($urandom_range(0, 9)) v = v * 10;
        v = v + 32'($urandom_range(0, 2)) - 32'd1;
      end
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off when a test asks for one
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character: text_char=%h last=%b",
               out_data_o.text_char, out_data_o.last);
        error_count++;
      end else begin
        want_char = expected_chars.pop_front();
        if (out_data_o.text_char !== want_char.text_char) begin
          $error("text_char mismatch: expected %h actual %h",
                 want_char.text_char, out_data_o.text_char);
          error_count++;
        end
        if (out_data_o.last !== want_char.last) begin
          $error("last mismatch: expected %b actual %b", want_char.last, out_data_o.last);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_reset();
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
  endtask

  // Field extremes, every kind, and the corner cases of each format
  task automatic test_directed_formats();
    max_gap = 0;
    stall_pct = 0;
    send_value(make_item(32'h0000_0000, KIND_SDEC, 1'b0));
    send_value(make_item(32'h8000_0000, KIND_SDEC, 1'b0));   // most negative integer
    send_value(make_item(32'h7FFF_FFFF, KIND_SDEC, 1'b1));
    send_value(make_item(32'hFFFF_FFFF, KIND_SDEC, 1'b0));
    send_value(make_item(32'h0000_0000, KIND_UDEC, 1'b0));
    send_value(make_item(32'hFFFF_FFFF, KIND_UDEC, 1'b1));
    send_value(make_item(32'hDEAD_BEEF, KIND_HEXL, 1'b1));
    send_value(make_item(32'h0123_4567, KIND_HEXL, 1'b0));
    send_value(make_item(32'hABCD_EF89, KIND_HEXU, 1'b1));
    send_value(make_item(32'hFFFF_FFFF, KIND_HEXU, 1'b0));
    send_value(make_item(32'hA5A5_A5A5, KIND_BIN, 1'b1));
    send_value(make_item(32'h0000_0000, KIND_BIN, 1'b0));
    send_value(make_item(32'hFFFF_FFFF, KIND_BINSP, 1'b0));
    send_value(make_item(32'h0000_0000, KIND_BINSP, 1'b1));
    send_value(make_item(32'd0, KIND_SIZE1K, 1'b0));
    send_value(make_item(32'd1023, KIND_SIZE1K, 1'b0));
    send_value(make_item(32'd1024, KIND_SIZE1K, 1'b1));
    send_value(make_item(32'd1048575, KIND_SIZE1K, 1'b0));
    send_value(make_item(32'd1048576, KIND_SIZE1K, 1'b0));
    send_value(make_item(32'hFFFF_FFFF, KIND_SIZE1K, 1'b0));  // three divisions
    send_value(make_item(32'd0, KIND_SIZE1M, 1'b1));
    send_value(make_item(32'd1048575, KIND_SIZE1M, 1'b0));   // largest plain byte count
    send_value(make_item(32'd1048576, KIND_SIZE1M, 1'b0));
    send_value(make_item(32'h4000_0000, KIND_SIZE1M, 1'b0));  // stays at MB
    send_value(make_item(32'hFFFF_FFFF, KIND_SIZE1M, 1'b1));
  endtask

  // Random values and kinds; idling profile changes every few dozen
  task automatic test_random_values();
    int n;
    for (n = 0; n < 260; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 75;
        endcase
        case ($urandom_range(0, 2))
          0: max_gap = 0;
          1: max_gap = 4;
          default: max_gap = 20;
        endcase
      end
      send_value(make_item(pick_value(), 3'($urandom_range(0, 7)),
                           1'($urandom_range(0, 1))));
    end
  endtask

  // Long receiver hold-off with the sender pushing, then a full drain and a second round with random idling
  task automatic test_backpressure();
    int n;
    max_gap = 0;
    stall_pct = 0;
    hold_request = 300;
    for (n = 0; n < 15; n++)
      send_value(make_item(pick_value(), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))));
    in_valid_i <= 1'b0;
    wait (expected_chars.size() == 0);
    @(negedge clk_i);
    stall_pct = 30;
    max_gap = 6;
    for (n = 0; n < 15; n++)
      send_value(make_item(pick_value(), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))));
  endtask

  // Full throughput: no gaps, no stalls
  task automatic test_streaming();
    int n;
    max_gap = 0;
    stall_pct = 0;
    for (n = 0; n < 50; n++)
      send_value(make_item(pick_value(), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))));
  endtask

  initial begin
    test_reset();
    test_directed_formats();
    test_random_values();
    test_backpressure();
    test_streaming();
    in_valid_i <= 1'b0;
    stall_pct = 10;
    wait (expected_chars.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
